// File: src/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants for the distance-vector route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

    localparam int NODES_DEF = 256;
    localparam int PORTS_DEF = 16;

    localparam int ID_W       = 8;
    localparam int GATE_W     = 4;
    localparam int COST_W     = 16;
    localparam int SEQ_W      = 16;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 9;
    localparam int FUNC_W     = 2;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [COST_W-1:0] COST_INF      = 16'hFFFF;
    localparam logic [COST_W-1:0] LINK_COST_RST = 16'd256;
    localparam logic [15:0]       ROUTE_TO_RST  = 16'd30;
    localparam logic [15:0]       HOLD_TO_RST   = 16'd10;

    // result word layout
    localparam int OUT_CHANGED_BIT = 0;
    localparam int OUT_FRESH_BIT   = 1;
    localparam int OUT_REMOVED_LSB = 18;
    localparam int OUT_PENDING_BIT = 36;

    typedef enum logic [1:0] {
        FUNC_HELLO  = 2'd0,
        FUNC_ROUTE  = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_UNUSED = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CFG_ROUTER_ID     = 2'd0,
        CFG_LINK_COST     = 2'd1,
        CFG_ROUTE_TIMEOUT = 2'd2,
        CFG_HOLD_TIMEOUT  = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_HELLO,
        OP_RT_READ,
        OP_RT_WRITE,
        OP_TICK,
        OP_NB_READ,
        OP_NB_EVAL,
        OP_RS_READ,
        OP_RS_EVAL,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        func_t func;
        logic  args_ok;
        logic  last_idx;
    } dp_status_t;

endpackage

// File: src/dvrt_ctrl.sv
// ----------------------------------------------------------------------------
// dvrt_ctrl
// Sequencer: decodes the item kind, walks the tables on a tick, and owns
// the stream handshakes.
// ----------------------------------------------------------------------------
module dvrt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  dvrt_pkg::dp_status_t status,
    output dvrt_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_HELLO,
        ST_RT_RD,
        ST_RT_WR,
        ST_TICK,
        ST_NB_RD,
        ST_NB_EV,
        ST_RS_RD,
        ST_RS_EV,
        ST_FIN
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd.op = dvrt_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE:     cmd.op = s_tvalid ? dvrt_pkg::OP_LOAD : dvrt_pkg::OP_NONE;
            ST_DISPATCH: cmd.op = dvrt_pkg::OP_NONE;
            ST_HELLO:    cmd.op = dvrt_pkg::OP_HELLO;
            ST_RT_RD:    cmd.op = dvrt_pkg::OP_RT_READ;
            ST_RT_WR:    cmd.op = dvrt_pkg::OP_RT_WRITE;
            ST_TICK:     cmd.op = dvrt_pkg::OP_TICK;
            ST_NB_RD:    cmd.op = dvrt_pkg::OP_NB_READ;
            ST_NB_EV:    cmd.op = dvrt_pkg::OP_NB_EVAL;
            ST_RS_RD:    cmd.op = dvrt_pkg::OP_RS_READ;
            ST_RS_EV:    cmd.op = dvrt_pkg::OP_RS_EVAL;
            ST_FIN:      cmd.op = out_free ? dvrt_pkg::OP_RESULT : dvrt_pkg::OP_NONE;
            default:     cmd.op = dvrt_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_FIN && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    unique case (status.func)
                        dvrt_pkg::FUNC_HELLO: state_reg <= status.args_ok ? ST_HELLO : ST_FIN;
                        dvrt_pkg::FUNC_ROUTE: state_reg <= status.args_ok ? ST_RT_RD : ST_FIN;
                        dvrt_pkg::FUNC_TICK:  state_reg <= ST_TICK;
                        default:              state_reg <= ST_FIN;
                    endcase
                end
                ST_HELLO: state_reg <= ST_FIN;
                ST_RT_RD: state_reg <= ST_RT_WR;
                ST_RT_WR: state_reg <= ST_FIN;
                ST_TICK:  state_reg <= ST_NB_RD;
                ST_NB_RD: state_reg <= ST_NB_EV;
                ST_NB_EV: state_reg <= status.last_idx ? ST_RS_RD : ST_NB_RD;
                ST_RS_RD: state_reg <= ST_RS_EV;
                ST_RS_EV: state_reg <= status.last_idx ? ST_FIN : ST_RS_RD;
                ST_FIN: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: src/dvrt_datapath.sv
// ----------------------------------------------------------------------------
// dvrt_datapath
// Configuration registers, route/neighbor/sequence stores, the cost and
// freshness logic, and the result register.
// ----------------------------------------------------------------------------
module dvrt_datapath #(
    parameter int NODES = dvrt_pkg::NODES_DEF,
    parameter int PORTS = dvrt_pkg::PORTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dvrt_pkg::dp_cmd_t                   cmd,
    output dvrt_pkg::dp_status_t                status,
    input  logic [dvrt_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic [dvrt_pkg::FUNC_W-1:0]         s_tuser,
    output logic [dvrt_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [dvrt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dvrt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int IW = $clog2(NODES);
    localparam int PW = $clog2(PORTS);
    localparam int KW = $clog2(NODES + 1);

    typedef struct packed {
        logic [dvrt_pkg::GATE_W-1:0] port;
        logic [dvrt_pkg::COST_W-1:0] metric;
        logic [dvrt_pkg::SEQ_W-1:0]  seqnum;
        logic [dvrt_pkg::TIME_W-1:0] expiry;
    } route_ent_t;

    typedef struct packed {
        logic [dvrt_pkg::GATE_W-1:0] port;
        logic [dvrt_pkg::TIME_W-1:0] last_seen;
    } nbr_ent_t;

    // configuration
    logic [dvrt_pkg::ID_W-1:0]   router_id_reg;
    logic [dvrt_pkg::COST_W-1:0] link_cost_reg;
    logic [15:0]                 route_to_reg;
    logic [15:0]                 hold_to_reg;

    // captured item
    dvrt_pkg::func_t             func_reg;
    logic [dvrt_pkg::ID_W-1:0]   sender_reg;
    logic [dvrt_pkg::GATE_W-1:0] gate_reg;
    logic [dvrt_pkg::ID_W-1:0]   dest_reg;
    logic [dvrt_pkg::COST_W-1:0] adv_cost_reg;
    logic [dvrt_pkg::SEQ_W-1:0]  adv_seq_reg;

    // table state
    logic [dvrt_pkg::TIME_W-1:0] now_reg;
    logic [NODES-1:0]            route_present_reg;
    logic [NODES-1:0]            route_valid_reg;
    logic [NODES-1:0]            seq_ok_reg;
    logic [NODES-1:0]            nbr_present_reg;
    logic                        pending_reg;
    logic [KW-1:0]               gate_cnt_reg [PORTS];
    logic [IW-1:0]               idx_reg;

    // per-item accumulators
    logic                         changed_reg;
    logic                         fresh_reg;
    logic [dvrt_pkg::COST_W-1:0]  total_reg;
    logic [dvrt_pkg::COUNT_W-1:0] removed_reg;
    logic [dvrt_pkg::COUNT_W-1:0] expired_reg;
    logic [dvrt_pkg::M_DATA_W-1:0] out_reg;

    // stores
    route_ent_t                  route_mem    [NODES];
    logic [dvrt_pkg::SEQ_W-1:0]  seq_mem      [NODES];
    logic [dvrt_pkg::GATE_W-1:0] nbr_port_mem [NODES];
    logic [dvrt_pkg::TIME_W-1:0] nbr_seen_mem [NODES];
    route_ent_t                  route_rd_reg;
    logic [dvrt_pkg::SEQ_W-1:0]  seq_rd_reg;
    nbr_ent_t                    nbr_rd_reg;

    logic [IW-1:0]               sender_idx, dest_idx;
    logic                        sender_ok, gate_ok, dest_ok, sender_known;
    logic [16:0]                 cost_sum;
    logic [dvrt_pkg::COST_W-1:0] total_via;
    logic                        take;
    logic [dvrt_pkg::TIME_W-1:0] expiry_new;
    logic [dvrt_pkg::TIME_W-1:0] nbr_age;
    logic                        nbr_stale;
    logic [PW-1:0]               nb_port_idx, rt_port_idx;
    logic [KW-1:0]               gate_hits;
    logic                        idx_is_self;
    logic                        poison_nb, poison_exp, poison_any;
    logic [dvrt_pkg::SEQ_W-1:0]  seq_base, seq_new;

    logic                        rmem_we, rmem_re;
    logic [IW-1:0]               rmem_waddr, rmem_raddr;
    route_ent_t                  rmem_wdata;
    logic                        nmem_we;

    // ---------------- decode ----------------
    assign sender_idx   = IW'(sender_reg);
    assign dest_idx     = IW'(dest_reg);
    assign sender_ok    = 32'(sender_reg) < NODES;
    assign gate_ok      = 32'(gate_reg) < PORTS;
    assign dest_ok      = 32'(dest_reg) < NODES;
    assign sender_known = nbr_present_reg[sender_idx];

    always_comb begin
        status.func     = func_reg;
        status.last_idx = (idx_reg == IW'(NODES - 1));
        if (func_reg == dvrt_pkg::FUNC_HELLO) begin
            status.args_ok = sender_ok && gate_ok;
        end else begin
            status.args_ok = sender_ok && gate_ok && dest_ok && (dest_reg != router_id_reg);
        end
    end

    // ---------------- route entry ----------------
    assign cost_sum   = {1'b0, adv_cost_reg} + {1'b0, link_cost_reg};
    assign expiry_new = now_reg + 32'(route_to_reg);

    always_comb begin
        total_via = adv_cost_reg;
        if (adv_cost_reg != dvrt_pkg::COST_INF && sender_known) begin
            total_via = cost_sum[16] ? dvrt_pkg::COST_INF : cost_sum[15:0];
        end
        if (!route_present_reg[dest_idx]) begin
            take = (adv_cost_reg != dvrt_pkg::COST_INF);
        end else begin
            take = (adv_seq_reg > route_rd_reg.seqnum) ||
                   ((adv_seq_reg == route_rd_reg.seqnum) && (total_via < route_rd_reg.metric));
        end
    end

    // ---------------- tick walk ----------------
    assign nbr_age     = now_reg - nbr_rd_reg.last_seen;
    assign nbr_stale   = nbr_present_reg[idx_reg] && (nbr_age > 32'(hold_to_reg));
    assign nb_port_idx = PW'(nbr_rd_reg.port);
    assign rt_port_idx = PW'(route_rd_reg.port);
    assign gate_hits   = gate_cnt_reg[rt_port_idx];
    assign idx_is_self = (32'(idx_reg) == 32'(router_id_reg));
    assign seq_base    = seq_ok_reg[idx_reg] ? seq_rd_reg : '0;

    // routes through removed neighbors take one bump per removed neighbor;
    // such a route is poisoned here, so the expiry test skips it
    assign poison_nb  = route_present_reg[idx_reg] && (gate_hits != '0);
    assign poison_exp = route_present_reg[idx_reg] && !poison_nb && route_valid_reg[idx_reg] &&
                        !idx_is_self && (now_reg > route_rd_reg.expiry);
    assign poison_any = poison_nb || poison_exp;
    assign seq_new    = seq_base + (poison_nb ? dvrt_pkg::SEQ_W'(gate_hits) : 16'd1);

    // ---------------- store ports ----------------
    always_comb begin
        rmem_we    = 1'b0;
        rmem_waddr = idx_reg;
        rmem_wdata = route_rd_reg;
        unique case (cmd.op)
            dvrt_pkg::OP_HELLO: begin
                rmem_we    = !sender_known;
                rmem_waddr = sender_idx;
                rmem_wdata = '{port: gate_reg, metric: link_cost_reg, seqnum: '0,
                               expiry: expiry_new};
            end
            dvrt_pkg::OP_RT_WRITE: begin
                rmem_we    = take;
                rmem_waddr = dest_idx;
                rmem_wdata = '{port: gate_reg, metric: total_via, seqnum: adv_seq_reg,
                               expiry: expiry_new};
            end
            dvrt_pkg::OP_RS_EVAL: begin
                rmem_we           = poison_any;
                rmem_wdata.metric = dvrt_pkg::COST_INF;
                rmem_wdata.seqnum = seq_new;
            end
            default: rmem_we = 1'b0;
        endcase
    end

    assign rmem_re    = (cmd.op == dvrt_pkg::OP_RT_READ) || (cmd.op == dvrt_pkg::OP_RS_READ);
    assign rmem_raddr = (cmd.op == dvrt_pkg::OP_RT_READ) ? dest_idx : idx_reg;
    assign nmem_we    = (cmd.op == dvrt_pkg::OP_HELLO);

    always_ff @(posedge aclk) begin
        if (rmem_we) begin
            route_mem[rmem_waddr] <= rmem_wdata;
        end
        if (rmem_re) begin
            route_rd_reg <= route_mem[rmem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == dvrt_pkg::OP_RS_EVAL && poison_any) begin
            seq_mem[idx_reg] <= seq_new;
        end
        if (cmd.op == dvrt_pkg::OP_RS_READ) begin
            seq_rd_reg <= seq_mem[idx_reg];
        end
    end

    // a known neighbor keeps its gate; only its last-seen time moves
    always_ff @(posedge aclk) begin
        if (nmem_we) begin
            nbr_seen_mem[sender_idx] <= now_reg;
            if (!sender_known) begin
                nbr_port_mem[sender_idx] <= gate_reg;
            end
        end
        if (cmd.op == dvrt_pkg::OP_NB_READ) begin
            nbr_rd_reg <= '{port: nbr_port_mem[idx_reg], last_seen: nbr_seen_mem[idx_reg]};
        end
    end

    // ---------------- control state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            router_id_reg     <= '0;
            link_cost_reg     <= dvrt_pkg::LINK_COST_RST;
            route_to_reg      <= dvrt_pkg::ROUTE_TO_RST;
            hold_to_reg       <= dvrt_pkg::HOLD_TO_RST;
            now_reg           <= '0;
            route_present_reg <= '0;
            route_valid_reg   <= '0;
            seq_ok_reg        <= '0;
            nbr_present_reg   <= '0;
            pending_reg       <= 1'b0;
            idx_reg           <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (dvrt_pkg::cfg_idx_t'(cfg_index))
                    dvrt_pkg::CFG_ROUTER_ID:     router_id_reg <= cfg_wdata[dvrt_pkg::ID_W-1:0];
                    dvrt_pkg::CFG_LINK_COST:     link_cost_reg <= cfg_wdata;
                    dvrt_pkg::CFG_ROUTE_TIMEOUT: route_to_reg  <= cfg_wdata;
                    dvrt_pkg::CFG_HOLD_TIMEOUT:  hold_to_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            unique case (cmd.op)
                dvrt_pkg::OP_HELLO: begin
                    if (!sender_known) begin
                        nbr_present_reg[sender_idx]   <= 1'b1;
                        route_present_reg[sender_idx] <= 1'b1;
                        route_valid_reg[sender_idx]   <= 1'b1;
                        pending_reg                   <= 1'b1;
                    end
                end
                dvrt_pkg::OP_RT_WRITE: begin
                    if (take) begin
                        route_present_reg[dest_idx] <= 1'b1;
                        route_valid_reg[dest_idx]   <= 1'b1;
                        pending_reg                 <= 1'b1;
                    end
                end
                dvrt_pkg::OP_TICK: begin
                    now_reg <= now_reg + 32'd1;
                    idx_reg <= '0;
                end
                dvrt_pkg::OP_NB_EVAL: begin
                    if (nbr_stale) begin
                        nbr_present_reg[idx_reg] <= 1'b0;
                        pending_reg              <= 1'b1;
                    end
                    idx_reg <= status.last_idx ? '0 : idx_reg + IW'(1);
                end
                dvrt_pkg::OP_RS_EVAL: begin
                    if (poison_any) begin
                        route_valid_reg[idx_reg] <= 1'b0;
                        seq_ok_reg[idx_reg]      <= 1'b1;
                        pending_reg              <= 1'b1;
                    end
                    idx_reg <= idx_reg + IW'(1);
                end
                default: ;
            endcase
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            dvrt_pkg::OP_LOAD: begin
                func_reg     <= dvrt_pkg::func_t'(s_tuser);
                sender_reg   <= s_tdata[7:0];
                gate_reg     <= s_tdata[11:8];
                dest_reg     <= s_tdata[19:12];
                adv_cost_reg <= s_tdata[35:20];
                adv_seq_reg  <= s_tdata[51:36];
                changed_reg  <= 1'b0;
                fresh_reg    <= 1'b0;
                total_reg    <= '0;
                removed_reg  <= '0;
                expired_reg  <= '0;
            end
            dvrt_pkg::OP_HELLO: begin
                if (!sender_known) begin
                    changed_reg <= 1'b1;
                    fresh_reg   <= 1'b1;
                end
            end
            dvrt_pkg::OP_RT_WRITE: begin
                total_reg <= total_via;
                if (take) begin
                    changed_reg <= 1'b1;
                end
            end
            dvrt_pkg::OP_TICK: begin
                for (int p = 0; p < PORTS; p++) begin
                    gate_cnt_reg[p] <= '0;
                end
            end
            dvrt_pkg::OP_NB_EVAL: begin
                if (nbr_stale) begin
                    gate_cnt_reg[nb_port_idx] <= gate_cnt_reg[nb_port_idx] + KW'(1);
                    removed_reg               <= removed_reg + 9'd1;
                end
            end
            dvrt_pkg::OP_RS_EVAL: begin
                if (poison_any) begin
                    changed_reg <= 1'b1;
                end
                if (poison_exp) begin
                    expired_reg <= expired_reg + 9'd1;
                end
            end
            dvrt_pkg::OP_RESULT: begin
                out_reg <= {3'b000, pending_reg, expired_reg, removed_reg, total_reg,
                            fresh_reg, changed_reg};
            end
            default: ;
        endcase
    end

    assign m_tdata = out_reg;

endmodule

// File: src/distance_vector_route_table.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table
// Sequence-numbered distance-vector route table with neighbor hold timers.
// ----------------------------------------------------------------------------
// Each input transfer is a hello, one advertised route entry, or a one-second
// tick, and yields exactly one result transfer. A route entry does one
// read-modify-write of the single-port route store. A tick walks the neighbor
// store and then the route store, a read step and an evaluate step per entry
// each through their single-port memories. The input takes a new transfer once
// the previous item has moved into the result register; a result waiting on
// m_tready lets the next item in, but holds it before its own result is loaded.
// Reset clears all valid bits at once; there is no clearing pass. Configuration
// may be written only while no item is in flight.
// ----------------------------------------------------------------------------
module distance_vector_route_table #(
    parameter int NODES = dvrt_pkg::NODES_DEF,
    parameter int PORTS = dvrt_pkg::PORTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata from bit 0: sender_id[8], arrival_gate[4], destination[8],
    // adv_cost[16], adv_seq[16], zero fill[4]
    input  logic [dvrt_pkg::S_DATA_W-1:0]   s_tdata,
    // tuser: func[2] (hello, route entry, tick)
    input  logic [dvrt_pkg::FUNC_W-1:0]     s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata from bit 0: route_changed[1], new_neighbor[1], total_cost[16],
    // neighbors_removed[9], routes_expired[9], change_pending[1], zero fill[3]
    output logic [dvrt_pkg::M_DATA_W-1:0]   m_tdata,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [dvrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dvrt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    dvrt_pkg::dp_cmd_t    cmd;
    dvrt_pkg::dp_status_t status;

    // sequencer: handshakes and the walk order
    dvrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // stores, cost logic and result register
    dvrt_datapath #(
        .NODES (NODES),
        .PORTS (PORTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

// File: src/dvrt_checker.sv
// ----------------------------------------------------------------------------
// dvrt_checker
// Port-level checks on the route table's streams, bound to the top level.
// ----------------------------------------------------------------------------
module dvrt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dvrt_pkg::M_DATA_W-1:0] m_tdata
);

    logic seen_pending_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_pending_reg <= 1'b0;
        end else if (m_tvalid && m_tready && m_tdata[dvrt_pkg::OUT_PENDING_BIT]) begin
            seen_pending_reg <= 1'b1;
        end
    end

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one item at a time: input closes right after a transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input reopened before item finished");

    // change_pending is sticky
    a_pending_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && seen_pending_reg |-> m_tdata[dvrt_pkg::OUT_PENDING_BIT])
        else $error("change_pending fell");

    // a new neighbor always writes its direct route
    a_fresh_changes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[dvrt_pkg::OUT_FRESH_BIT] |-> m_tdata[dvrt_pkg::OUT_CHANGED_BIT])
        else $error("new neighbor without route change");

    // removing a neighbor marks the table changed
    a_removed_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[dvrt_pkg::OUT_REMOVED_LSB +: dvrt_pkg::COUNT_W] != '0)
        |-> m_tdata[dvrt_pkg::OUT_PENDING_BIT])
        else $error("neighbor removed without change_pending");

endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the distance-vector route table.
// ----------------------------------------------------------------------------
// Drives hellos, route entries, ticks and the unused selector through the
// input stream. A behavioral route table in this module predicts every result
// word; results are compared field by field in arrival order. The run steps
// through several register settings, among them the extremes, and includes a
// long receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES      = dvrt_pkg::NODES_DEF;
    localparam int PORTS      = dvrt_pkg::PORTS_DEF;
    localparam int RAND_ITEMS = 620;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 1200;

    typedef struct packed {
        logic [15:0] seq;
        logic [15:0] cost;
        logic [7:0]  dest;
        logic [3:0]  gate;
        logic [7:0]  sender;
    } item_t;

    typedef struct packed {
        logic        pending;
        logic [8:0]  expired;
        logic [8:0]  removed;
        logic [15:0] total;
        logic        fresh;
        logic        changed;
    } route_result_t;

    typedef struct {
        dvrt_pkg::func_t func;
        item_t item;
        logic  has_value;      // a typed-in result stands in this row
        route_result_t value;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [dvrt_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic [dvrt_pkg::FUNC_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [dvrt_pkg::M_DATA_W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [dvrt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [dvrt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    always #5 aclk = ~aclk;

    distance_vector_route_table dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // ---------------- predicted table state ----------------
    logic [7:0]  my_id;
    logic [15:0] hop_cost, route_life, hold_life;
    logic [31:0] clock_ticks;
    logic        rt_present [NODES];
    logic        rt_valid [NODES];
    logic [3:0]  rt_gate [NODES];
    logic [15:0] rt_cost [NODES];
    logic [15:0] rt_seq [NODES];
    logic [31:0] rt_expiry [NODES];
    logic [15:0] dest_seq_ctr [NODES];
    logic        nb_present [NODES];
    logic [3:0]  nb_gate [NODES];
    logic [31:0] nb_seen [NODES];
    logic        table_dirty;

    route_result_t pending_results[$];
    int errors = 0;
    int fed = 0;
    int got = 0;
    int ticks_fed = 0;
    bit long_stall = 1'b0;

    task automatic clear_table();
        my_id = 8'd0; hop_cost = 16'd256; route_life = 16'd30; hold_life = 16'd10;
        clock_ticks = '0; table_dirty = 1'b0;
        for (int i = 0; i < NODES; i++) begin
            rt_present[i] = 1'b0; rt_valid[i] = 1'b0; rt_gate[i] = '0;
            rt_cost[i] = '0; rt_seq[i] = '0; rt_expiry[i] = '0;
            dest_seq_ctr[i] = '0; nb_present[i] = 1'b0; nb_gate[i] = '0; nb_seen[i] = '0;
        end
    endtask

    function automatic void install_route(int d, logic [3:0] g, logic [15:0] c,
                                          logic [15:0] s);
        rt_present[d] = 1'b1; rt_valid[d] = 1'b1; rt_gate[d] = g;
        rt_cost[d] = c; rt_seq[d] = s;
        rt_expiry[d] = clock_ticks + 32'(route_life);
        table_dirty = 1'b1;
    endfunction

    function automatic void poison_route(int d);
        rt_valid[d] = 1'b0; rt_cost[d] = dvrt_pkg::COST_INF;
        dest_seq_ctr[d] = dest_seq_ctr[d] + 16'd1;
        rt_seq[d] = dest_seq_ctr[d];
        table_dirty = 1'b1;
    endfunction

    // Advance the table by one item and return the result it yields.
    function automatic route_result_t apply_item(dvrt_pkg::func_t f, item_t it);
        route_result_t r;
        logic [16:0] sum;
        logic take;
        r = '0;
        case (f)
            dvrt_pkg::FUNC_HELLO: begin
                if (!nb_present[it.sender]) begin
                    nb_present[it.sender] = 1'b1;
                    nb_gate[it.sender] = it.gate;
                    nb_seen[it.sender] = clock_ticks;
                    install_route(it.sender, it.gate, hop_cost, 16'd0);
                    r.changed = 1'b1; r.fresh = 1'b1;
                end else begin
                    nb_seen[it.sender] = clock_ticks;
                end
            end
            dvrt_pkg::FUNC_ROUTE: begin
                if (it.dest != my_id) begin
                    r.total = it.cost;
                    if (it.cost != dvrt_pkg::COST_INF && nb_present[it.sender]) begin
                        sum = {1'b0, it.cost} + {1'b0, hop_cost};
                        r.total = (sum > 17'(dvrt_pkg::COST_INF)) ? dvrt_pkg::COST_INF
                                                                  : sum[15:0];
                    end
                    if (!rt_present[it.dest])
                        take = (it.cost != dvrt_pkg::COST_INF);
                    else
                        take = (it.seq > rt_seq[it.dest]) ||
                               (it.seq == rt_seq[it.dest] && r.total < rt_cost[it.dest]);
                    if (take) begin
                        install_route(it.dest, it.gate, r.total, it.seq);
                        r.changed = 1'b1;
                    end
                end
            end
            dvrt_pkg::FUNC_TICK: begin
                clock_ticks = clock_ticks + 32'd1;
                for (int n = 0; n < NODES; n++) begin
                    if (nb_present[n] && (clock_ticks - nb_seen[n]) > 32'(hold_life)) begin
                        for (int d = 0; d < NODES; d++) begin
                            if (rt_present[d] && rt_gate[d] == nb_gate[n]) begin
                                poison_route(d);
                                r.changed = 1'b1;
                            end
                        end
                        nb_present[n] = 1'b0;
                        table_dirty = 1'b1;
                        r.removed = r.removed + 9'd1;
                    end
                end
                for (int d = 0; d < NODES; d++) begin
                    if (rt_present[d] && rt_valid[d] && d != int'(my_id) &&
                        clock_ticks > rt_expiry[d]) begin
                        poison_route(d);
                        r.changed = 1'b1;
                        r.expired = r.expired + 9'd1;
                    end
                end
            end
            default: ;
        endcase
        r.pending = table_dirty;
        return r;
    endfunction

    // ---------------- drivers ----------------
    task automatic write_reg(dvrt_pkg::cfg_idx_t idx, logic [15:0] val);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            dvrt_pkg::CFG_ROUTER_ID:     my_id = val[7:0];
            dvrt_pkg::CFG_LINK_COST:     hop_cost = val;
            dvrt_pkg::CFG_ROUTE_TIMEOUT: route_life = val;
            default:                     hold_life = val;
        endcase
    endtask

    // Offer one item, hold it until the transfer, then log its prediction.
    task automatic send_item(dvrt_pkg::func_t f, item_t it, logic typed, route_result_t val);
        route_result_t r;
        s_tvalid <= 1'b1; s_tuser <= f; s_tdata <= {4'b0, it};
        do @(posedge aclk); while (!s_tready);
        r = apply_item(f, it);
        if (typed && r !== val)
            $error("typed-in result %h differs from predicted %h", val, r);
        pending_results.insert(pending_results.size(), r);
        fed++;
        if (f == dvrt_pkg::FUNC_TICK) ticks_fed++;
    endtask

    // Drop valid for a random gap, sometimes none so bursts run back to back.
    task automatic sender_gap();
        int g;
        g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // ---------------- receiver and checker ----------------
    always @(posedge aclk) begin
        if (!aresetn || long_stall) begin
            m_tready <= 1'b0;
        end else begin
            case ((got / 40) % 3)
                0: m_tready <= 1'b1;                       // no stalls
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        route_result_t act, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            act = m_tdata[36:0];
            got++;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (act.changed !== exp_r.changed) begin
                    $error("route_changed exp %0d got %0d", exp_r.changed, act.changed); errors++;
                end
                if (act.fresh !== exp_r.fresh) begin
                    $error("new_neighbor exp %0d got %0d", exp_r.fresh, act.fresh); errors++;
                end
                if (act.total !== exp_r.total) begin
                    $error("total_cost exp %0d got %0d", exp_r.total, act.total); errors++;
                end
                if (act.removed !== exp_r.removed) begin
                    $error("neighbors_removed exp %0d got %0d", exp_r.removed, act.removed);
                    errors++;
                end
                if (act.expired !== exp_r.expired) begin
                    $error("routes_expired exp %0d got %0d", exp_r.expired, act.expired);
                    errors++;
                end
                if (act.pending !== exp_r.pending) begin
                    $error("change_pending exp %0d got %0d", exp_r.pending, act.pending);
                    errors++;
                end
                if (m_tdata[39:37] !== 3'b000) begin
                    $error("zero fill exp 0 got %0d", m_tdata[39:37]); errors++;
                end
            end
        end
    end

    // Watchdog: count cycles without any transfer.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn || long_stall)
            idle_cycles <= 0;
        else if (s_tvalid || pending_results.size() != 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- random item shaping ----------------
    // Ids come mostly from a small pool so hellos, routes and ticks interact.
    function automatic logic [7:0] pick_id();
        return ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 11));
    endfunction

    function automatic item_t random_item(dvrt_pkg::func_t f);
        item_t it;
        it.sender = pick_id();
        it.gate = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
        it.dest = pick_id();
        case ($urandom_range(0, 5))
            0: it.cost = dvrt_pkg::COST_INF;
            1: it.cost = 16'($urandom);
            2: it.cost = 16'hFFFE - 16'($urandom_range(0, 3));
            default: it.cost = 16'($urandom_range(0, 2048));
        endcase
        // sequence numbers near the stored ones, with wide jumps now and then
        it.seq = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                 : ((f == dvrt_pkg::FUNC_ROUTE && rt_present[it.dest])
                    ? rt_seq[it.dest] + 16'($urandom_range(0, 2)) - 16'd1
                    : 16'($urandom_range(0, 4)));
        return it;
    endfunction

    function automatic dvrt_pkg::func_t random_func();
        int p;
        p = $urandom_range(0, 99);
        if (p < 25) return dvrt_pkg::FUNC_HELLO;
        if (p < 80) return dvrt_pkg::FUNC_ROUTE;
        if (p < 97) return dvrt_pkg::FUNC_TICK;
        return dvrt_pkg::FUNC_UNUSED;
    endfunction

    // ---------------- directed table ----------------
    stim_row_t directed[$];

    function automatic stim_row_t row(dvrt_pkg::func_t f, logic [7:0] snd, logic [3:0] g,
                                      logic [7:0] d, logic [15:0] c, logic [15:0] s,
                                      logic typed, route_result_t v);
        stim_row_t r;
        r.func = f; r.item = '{seq: s, cost: c, dest: d, gate: g, sender: snd};
        r.has_value = typed; r.value = v;
        return r;
    endfunction

    // Append one row to the directed table.
    function automatic void queue_row(stim_row_t r);
        directed.insert(directed.size(), r);
    endfunction

    initial begin
        route_result_t nil;
        route_result_t v;
        nil = '0;
        clear_table();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // after reset: empty table, defaults (router 0, cost 1.0)
        v = nil; v.pending = 1'b1; v.changed = 1'b1; v.fresh = 1'b1;
        queue_row(row(dvrt_pkg::FUNC_HELLO, 8'd5, 4'd2, 8'd0, 16'd0, 16'd0, 1'b1, v));
        queue_row(row(dvrt_pkg::FUNC_HELLO, 8'd5, 4'd2, 8'd0, 16'd0, 16'd0, 1'b0, nil));
        queue_row(row(dvrt_pkg::FUNC_HELLO, 8'd255, 4'd15, 8'hFF, 16'hFFFF, 16'hFFFF,
                      1'b0, nil));
        // own destination is skipped
        v = nil; v.pending = 1'b1;
        queue_row(row(dvrt_pkg::FUNC_ROUTE, 8'd5, 4'd2, 8'd0, 16'd100, 16'd9, 1'b1, v));
        queue_row(row(dvrt_pkg::FUNC_ROUTE, 8'd5, 4'd2, 8'd7, 16'd512, 16'd4, 1'b0, nil));
        queue_row(row(dvrt_pkg::FUNC_ROUTE, 8'd5, 4'd2, 8'd7, 16'd100, 16'd4, 1'b0, nil));
        queue_row(row(dvrt_pkg::FUNC_ROUTE, 8'd5, 4'd2, 8'd7, 16'd900, 16'd4, 1'b0, nil));
        queue_row(row(dvrt_pkg::FUNC_ROUTE, 8'd5, 4'd3, 8'd7, 16'd900, 16'd5, 1'b0, nil));
        // saturation, infinity, unknown sender, absent infinite destination
        queue_row(row(dvrt_pkg::FUNC_ROUTE, 8'd5, 4'd2, 8'd8, 16'hFFFE, 16'd1, 1'b0, nil));
        queue_row(row(dvrt_pkg::FUNC_ROUTE, 8'd5, 4'd2, 8'd9, 16'hFFFF, 16'd1, 1'b0, nil));
        queue_row(row(dvrt_pkg::FUNC_ROUTE, 8'd77, 4'd1, 8'd10, 16'd300, 16'd0, 1'b0, nil));
        queue_row(row(dvrt_pkg::FUNC_ROUTE, 8'd5, 4'd2, 8'd255, 16'hFFFF, 16'hFFFF,
                      1'b0, nil));
        queue_row(row(dvrt_pkg::FUNC_ROUTE, 8'd5, 4'd2, 8'd7, 16'hFFFF, 16'hFFFF, 1'b0, nil));
        queue_row(row(dvrt_pkg::FUNC_UNUSED, 8'hFF, 4'hF, 8'hFF, 16'hFFFF, 16'hFFFF,
                      1'b0, nil));
        for (int i = 0; i < 12; i++)
            queue_row(row(dvrt_pkg::FUNC_TICK, 8'd0, 4'd0, 8'd0, 16'd0, 16'd0, 1'b0, nil));
        foreach (directed[i])
            send_item(directed[i].func, directed[i].item, directed[i].has_value,
                      directed[i].value);
        drain();

        // random phases, each under a different register setting
        for (int ph = 0; ph < 5; ph++) begin
            repeat (DRAIN_WAIT) @(posedge aclk);
            case (ph)
                0: begin
                    write_reg(dvrt_pkg::CFG_ROUTER_ID, 16'd255);
                    write_reg(dvrt_pkg::CFG_LINK_COST, 16'd0);
                    write_reg(dvrt_pkg::CFG_ROUTE_TIMEOUT, 16'd1);
                    write_reg(dvrt_pkg::CFG_HOLD_TIMEOUT, 16'd1);
                end
                1: begin
                    write_reg(dvrt_pkg::CFG_ROUTER_ID, 16'd3);
                    write_reg(dvrt_pkg::CFG_LINK_COST, 16'd65534);
                    write_reg(dvrt_pkg::CFG_ROUTE_TIMEOUT, 16'd65535);
                    write_reg(dvrt_pkg::CFG_HOLD_TIMEOUT, 16'd65535);
                end
                2: begin
                    write_reg(dvrt_pkg::CFG_ROUTER_ID, 16'd0);
                    write_reg(dvrt_pkg::CFG_LINK_COST, 16'd256);
                    write_reg(dvrt_pkg::CFG_ROUTE_TIMEOUT, 16'd4);
                    write_reg(dvrt_pkg::CFG_HOLD_TIMEOUT, 16'd3);
                end
                3: begin
                    write_reg(dvrt_pkg::CFG_ROUTER_ID, 16'($urandom_range(0, 11)));
                    write_reg(dvrt_pkg::CFG_LINK_COST, 16'($urandom_range(1, 1000)));
                    write_reg(dvrt_pkg::CFG_ROUTE_TIMEOUT, 16'($urandom_range(2, 8)));
                    write_reg(dvrt_pkg::CFG_HOLD_TIMEOUT, 16'($urandom_range(1, 6)));
                end
                default: begin
                    write_reg(dvrt_pkg::CFG_ROUTER_ID, 16'd170);
                    write_reg(dvrt_pkg::CFG_LINK_COST, 16'd43690);
                    write_reg(dvrt_pkg::CFG_ROUTE_TIMEOUT, 16'd21845);
                    write_reg(dvrt_pkg::CFG_HOLD_TIMEOUT, 16'd2);
                end
            endcase
            for (int k = 0; k < RAND_ITEMS / 5; k++) begin
                dvrt_pkg::func_t f;
                f = random_func();
                // hold the receiver off midway so the block backs up
                if (ph == 2 && k == 20) begin
                    fork
                        begin
                            long_stall = 1'b1;
                            repeat (300) @(posedge aclk);
                            long_stall = 1'b0;
                        end
                    join_none
                end
                send_item(f, random_item(f), 1'b0, nil);
                sender_gap();
            end
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("Covered %0d items (%0d ticks), %0d results checked, 6 register settings.",
                 fed, ticks_fed, got);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
